// ===== hw/rtl/sde_pkg.sv =====
// Shared types and constants for the scanline displacement block.
// Request, response and sequencer types; no dependencies.
`timescale 1ns / 1ps

package sde_pkg;

   localparam int FRAME_W_LIMIT = 256;
   localparam int FRAME_H_LIMIT = 256;
   localparam int LUMA_DEPTH    = FRAME_W_LIMIT * FRAME_H_LIMIT;
   localparam int CHROMA_DEPTH  = (FRAME_W_LIMIT / 2) * (FRAME_H_LIMIT / 2);
   localparam int LUMA_AW       = $clog2(LUMA_DEPTH);
   localparam int CHROMA_AW     = $clog2(CHROMA_DEPTH);

   localparam logic [1:0] PLANE_LUMA = 2'd0;
   localparam logic [1:0] PLANE_CR   = 2'd1;
   localparam logic [1:0] PLANE_CB   = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_APPLY = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_LINE_SPACING   = 3'd2,
      CSR_VERTICAL_SCALE = 3'd3,
      CSR_LUMA_COLOR     = 3'd4,
      CSR_CR_COLOR       = 3'd5,
      CSR_CB_COLOR       = 3'd6,
      CSR_CHROMA_RANGE   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_AP_READ,
      ST_AP_LOAD,
      ST_AP_DIV,
      ST_AP_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] plane;
      logic [7:0] column;
      logic [7:0] row;
      logic [7:0] sample;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] finished_operation;
   } rsp_type;

endpackage

// ===== hw/rtl/scanline_displacement_effect.sv =====
// Scanline displacement effect: frame stores, sequencer and shared divider.
// Depends on sde_pkg for payload, state and register codes.
//
// Usage: a 4:2:0 frame (luma, half-size Cr and Cb) is held in on-chip memory.
// Words arrive on req_* (valid/stall) and each gives exactly one word on
// rsp_* (valid/stall). The csr_* port writes the eight settings registers;
// csr_ready is always high, and writes belong in idle periods only.
// Load and no-op responses are registered at the accept edge. A read passes
// the memory port register, then ST_READ_WAIT registers its response. Apply
// walks every line_spacing-th row of luma, and of each chroma plane when
// chroma_range is nonzero; each pixel takes memory read, data capture, eight
// steps of the shared restoring divider and write-back, with a plane-end
// step after each plane; ST_DONE posts the response. One request is in flight
// at a time; req_stall is high while the sequencer is busy or while a
// response waits on a stalled receiver. A stalled response holds its word
// and the sequencer waits for the output register to free. Synchronous reset
// returns the sequencer to idle, empties the output register and restores
// the register defaults; memory contents are left as they are.
`timescale 1ns / 1ps

module scanline_displacement_effect
   import sde_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [8:0]    csr_data
);

   // settings registers
   logic [8:0] frame_width_ff, frame_height_ff, line_spacing_ff, vertical_scale_ff;
   logic [7:0] luma_color_ff, cr_color_ff, cb_color_ff;
   logic [2:0] chroma_range_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= 9'd256;
         frame_height_ff   <= 9'd256;
         line_spacing_ff   <= 9'd2;
         vertical_scale_ff <= 9'd42;
         luma_color_ff     <= 8'd201;
         cr_color_ff       <= 8'd128;
         cb_color_ff       <= 8'd128;
         chroma_range_ff   <= 3'd6;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_data;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_data;
            CSR_LINE_SPACING:   line_spacing_ff   <= csr_data;
            CSR_VERTICAL_SCALE: vertical_scale_ff <= csr_data;
            CSR_LUMA_COLOR:     luma_color_ff     <= csr_data[7:0];
            CSR_CR_COLOR:       cr_color_ff       <= csr_data[7:0];
            CSR_CB_COLOR:       cb_color_ff       <= csr_data[7:0];
            CSR_CHROMA_RANGE:   chroma_range_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   localparam logic [8:0] MAX_W = 9'(FRAME_W_LIMIT);
   localparam logic [8:0] MAX_H = 9'(FRAME_H_LIMIT);

   logic [8:0] eff_w, eff_h, eff_step, eff_scale;
   logic [7:0] eff_uw, eff_uh;

   always_comb begin
      if (frame_width_ff < 9'd2)     eff_w = 9'd2;
      else if (frame_width_ff > MAX_W) eff_w = MAX_W;
      else                           eff_w = frame_width_ff;
      if (frame_height_ff < 9'd2)    eff_h = 9'd2;
      else if (frame_height_ff > MAX_H) eff_h = MAX_H;
      else                           eff_h = frame_height_ff;
      eff_uw    = eff_w[8:1];
      eff_uh    = eff_h[8:1];
      eff_step  = (line_spacing_ff == 9'd0) ? 9'd1 : line_spacing_ff;
      eff_scale = (vertical_scale_ff == 9'd0) ? 9'd1 : vertical_scale_ff;
   end

   // sequencer and datapath registers
   state_type  state_ff, state_in;
   logic [1:0] plane_ff;
   logic       rd_zero_ff;
   logic [9:0] y_ff;
   logic [8:0] x_ff;
   logic [7:0] qd_ff;
   logic [7:0] rem_ff;
   logic [2:0] cnt_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   logic req_accept, out_free;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // plane geometry for the active address, the incoming word and the scan
   logic [1:0] mem_plane;
   logic [8:0] mem_pw, req_pw, req_ph;
   logic [8:0] cur_pw;
   logic [9:0] cur_ph;

   assign mem_pw = (mem_plane == PLANE_LUMA) ? eff_w : {1'b0, eff_uw};
   assign req_pw = (req_data.plane == PLANE_LUMA) ? eff_w : {1'b0, eff_uw};
   assign req_ph = (req_data.plane == PLANE_LUMA) ? eff_h : {1'b0, eff_uh};

   always_comb begin
      cur_pw = (plane_ff == PLANE_LUMA) ? eff_w : {1'b0, eff_uw};
      cur_ph = (plane_ff == PLANE_LUMA) ? {1'b0, eff_h} : {2'b0, eff_uh};
   end

   // shared address unit
   logic [7:0]  mem_row, mem_col;
   logic [LUMA_AW-1:0]   addr_full;
   logic [LUMA_AW-1:0]   luma_addr;
   logic [CHROMA_AW-1:0] chroma_addr;

   assign addr_full   = LUMA_AW'(mem_row * mem_pw) + LUMA_AW'(mem_col);
   assign luma_addr   = addr_full;
   assign chroma_addr = addr_full[CHROMA_AW-1:0];

   // shared restoring divider step
   logic [8:0] trial;
   logic       trial_ge;
   logic [7:0] trial_diff;
   assign trial      = {rem_ff, qd_ff[7]};
   assign trial_ge   = trial >= eff_scale;
   assign trial_diff = 8'(trial - eff_scale);

   logic [7:0] target_row;
   logic       hit;
   assign hit        = {2'b0, qd_ff} < y_ff;
   assign target_row = 8'(y_ff - {2'b0, qd_ff});

   logic req_in_range;
   assign req_in_range = (req_data.plane != 2'd3)
                         && ({1'b0, req_data.column} < req_pw)
                         && ({1'b0, req_data.row} < req_ph);

   logic row_end, plane_end;
   assign row_end   = (x_ff + 9'd1) == cur_pw;
   assign plane_end = y_ff >= cur_ph;

   // memories
   logic [7:0] luma_mem [LUMA_DEPTH];
   logic [7:0] cr_mem   [CHROMA_DEPTH];
   logic [7:0] cb_mem   [CHROMA_DEPTH];
   logic [7:0] luma_q_ff, cr_q_ff, cb_q_ff;
   logic       mem_we, mem_re;
   logic [7:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we && mem_plane == PLANE_LUMA) luma_mem[luma_addr] <= mem_wdata;
      if (mem_re && mem_plane == PLANE_LUMA) luma_q_ff <= luma_mem[luma_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_plane == PLANE_CR) cr_mem[chroma_addr] <= mem_wdata;
      if (mem_re && mem_plane == PLANE_CR) cr_q_ff <= cr_mem[chroma_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_plane == PLANE_CB) cb_mem[chroma_addr] <= mem_wdata;
      if (mem_re && mem_plane == PLANE_CB) cb_q_ff <= cb_mem[chroma_addr];
   end

   logic [7:0] q_sel;
   always_comb begin
      case (plane_ff)
         PLANE_LUMA: q_sel = luma_q_ff;
         PLANE_CR:   q_sel = cr_q_ff;
         PLANE_CB:   q_sel = cb_q_ff;
         default:    q_sel = 8'd0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (op_type'(req_data.operation))
                  OP_READ:  state_in = ST_READ_WAIT;
                  OP_APPLY: state_in = ST_AP_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_WAIT: if (out_free) state_in = ST_IDLE;
         ST_AP_READ: begin
            if (!plane_end)                  state_in = ST_AP_LOAD;
            else if (plane_ff == PLANE_CB)   state_in = ST_DONE;
            else if (plane_ff == PLANE_LUMA && chroma_range_ff == 3'd0)
                                             state_in = ST_DONE;
         end
         ST_AP_LOAD:  state_in = ST_AP_DIV;
         ST_AP_DIV:   if (cnt_ff == 3'd7) state_in = ST_AP_WRITE;
         ST_AP_WRITE: state_in = ST_AP_READ;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: memory control and response load
   logic    rsp_load;
   rsp_type rsp_load_data;

   always_comb begin
      mem_plane     = plane_ff;
      mem_row       = y_ff[7:0];
      mem_col       = x_ff[7:0];
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wdata     = req_data.sample;
      rsp_load      = 1'b0;
      rsp_load_data = '{read_data: 8'd0, finished_operation: OP_NONE};
      case (state_ff)
         ST_IDLE: begin
            mem_plane = req_data.plane;
            mem_row   = req_data.row;
            mem_col   = req_data.column;
            if (req_accept) begin
               case (op_type'(req_data.operation))
                  OP_LOAD: begin
                     mem_we   = req_in_range;
                     rsp_load = 1'b1;
                     rsp_load_data.finished_operation = OP_LOAD;
                  end
                  OP_READ: mem_re = req_in_range;
                  OP_NONE: begin
                     rsp_load = 1'b1;
                     rsp_load_data.finished_operation = OP_NONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_load = out_free;
            rsp_load_data.read_data = rd_zero_ff ? 8'd0 : q_sel;
            rsp_load_data.finished_operation = OP_READ;
         end
         ST_AP_READ: mem_re = !plane_end;
         ST_AP_WRITE: begin
            mem_row = target_row;
            mem_we  = hit;
            case (plane_ff)
               PLANE_LUMA: mem_wdata = luma_color_ff;
               PLANE_CR:   mem_wdata = cr_color_ff;
               default:    mem_wdata = cb_color_ff;
            endcase
         end
         ST_DONE: begin
            rsp_load = out_free;
            rsp_load_data.finished_operation = OP_APPLY;
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= rsp_load_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               plane_ff   <= (op_type'(req_data.operation) == OP_APPLY) ? PLANE_LUMA
                                                                         : req_data.plane;
               rd_zero_ff <= !req_in_range;
               y_ff       <= 10'd0;
               x_ff       <= 9'd0;
            end
         end
         ST_AP_READ: begin
            // move on to the next chroma plane once rows run out
            if (plane_end) begin
               y_ff <= 10'd0;
               x_ff <= 9'd0;
               if (plane_ff == PLANE_LUMA) plane_ff <= PLANE_CR;
               else                        plane_ff <= PLANE_CB;
            end
         end
         ST_AP_LOAD: begin
            qd_ff  <= (plane_ff == PLANE_LUMA) ? q_sel : {1'b0, q_sel[7:1]};
            rem_ff <= 8'd0;
            cnt_ff <= 3'd0;
         end
         ST_AP_DIV: begin
            rem_ff <= trial_ge ? trial_diff : trial[7:0];
            qd_ff  <= {qd_ff[6:0], trial_ge};
            cnt_ff <= cnt_ff + 3'd1;
         end
         ST_AP_WRITE: begin
            if (row_end) begin
               x_ff <= 9'd0;
               y_ff <= y_ff + {1'b0, eff_step};
            end else begin
               x_ff <= x_ff + 9'd1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the scanline displacement block: loads, reads and
// applies the effect on small frames against an in-bench frame predictor.
// Depends on sde_pkg and scanline_displacement_effect.
`timescale 1ns / 1ps

module tb
   import sde_pkg::*;
();

   localparam logic [1:0] PLANE_SPARE    = 2'd3;
   localparam int         ITEM_TARGET    = 1550;
   localparam int         HOLDOFF_CYCLES = 300;
   localparam int         REQ_BITS       = $bits(req_type);

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [8:0]    csr_data;

   // frame predictor state
   bit [7:0]   luma_mem [LUMA_DEPTH];
   bit [7:0]   cr_mem [CHROMA_DEPTH];
   bit [7:0]   cb_mem [CHROMA_DEPTH];
   bit         luma_known [LUMA_DEPTH];
   bit         cr_known [CHROMA_DEPTH];
   bit         cb_known [CHROMA_DEPTH];
   logic [8:0] cfg_width, cfg_height, cfg_spacing, cfg_scale;
   logic [7:0] cfg_luma, cfg_cr, cfg_cb;
   logic [2:0] cfg_chroma;

   rsp_type owed_rsp [$];
   int      words_sent = 0;
   int      error_count = 0;
   int      holdoff_requests = 0;
   bit      steady = 1'b0;

   scanline_displacement_effect dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int luma_width();
      return (cfg_width < 2) ? 2 : (cfg_width > FRAME_W_LIMIT) ? FRAME_W_LIMIT
                                                               : int'(cfg_width);
   endfunction

   function automatic int luma_height();
      return (cfg_height < 2) ? 2 : (cfg_height > FRAME_H_LIMIT) ? FRAME_H_LIMIT
                                                                 : int'(cfg_height);
   endfunction

   function automatic int plane_w(input logic [1:0] p);
      case (p)
         PLANE_LUMA:         return luma_width();
         PLANE_CR, PLANE_CB: return luma_width() >> 1;
         default:            return 0;
      endcase
   endfunction

   function automatic int plane_h(input logic [1:0] p);
      case (p)
         PLANE_LUMA:         return luma_height();
         PLANE_CR, PLANE_CB: return luma_height() >> 1;
         default:            return 0;
      endcase
   endfunction

   function automatic bit [7:0] mem_get(input logic [1:0] p, input int a);
      case (p)
         PLANE_LUMA: return luma_mem[a];
         PLANE_CR:   return cr_mem[a];
         PLANE_CB:   return cb_mem[a];
         default:    return 8'd0;
      endcase
   endfunction

   function automatic bit mem_known(input logic [1:0] p, input int a);
      case (p)
         PLANE_LUMA: return luma_known[a];
         PLANE_CR:   return cr_known[a];
         PLANE_CB:   return cb_known[a];
         default:    return 1'b0;
      endcase
   endfunction

   function automatic void mem_put(input logic [1:0] p, input int a, input bit [7:0] v);
      case (p)
         PLANE_LUMA: begin
            luma_mem[a]   = v;
            luma_known[a] = 1'b1;
         end
         PLANE_CR: begin
            cr_mem[a]   = v;
            cr_known[a] = 1'b1;
         end
         PLANE_CB: begin
            cb_mem[a]   = v;
            cb_known[a] = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Scan every step-th row left to right; writes land at or above the scan row.
   function automatic void displace_plane(input logic [1:0] p, input bit halve,
                                          input logic [7:0] color);
      int pw, ph, step, scale, s, off;
      pw    = plane_w(p);
      ph    = plane_h(p);
      step  = (cfg_spacing == 0) ? 1 : int'(cfg_spacing);
      scale = (cfg_scale == 0) ? 1 : int'(cfg_scale);
      for (int y = 0; y < ph; y += step) begin
         for (int x = 0; x < pw; x++) begin
            s = int'(mem_get(p, y * pw + x));
            if (halve)
               s = s >> 1;
            off = s / scale;
            if (off < y)
               mem_put(p, (y - off) * pw + x, color);
         end
      end
   endfunction

   function automatic rsp_type run_frame_op(input req_type w);
      rsp_type r;
      int      pw, ph;
      pw = plane_w(w.plane);
      ph = plane_h(w.plane);
      r.read_data          = 8'd0;
      r.finished_operation = w.operation;
      case (w.operation)
         OP_APPLY: begin
            displace_plane(PLANE_LUMA, 1'b0, cfg_luma);
            if (cfg_chroma != 0) begin
               displace_plane(PLANE_CR, 1'b1, cfg_cr);
               displace_plane(PLANE_CB, 1'b1, cfg_cb);
            end
         end
         OP_LOAD: begin
            if (int'(w.column) < pw && int'(w.row) < ph)
               mem_put(w.plane, int'(w.row) * pw + int'(w.column), w.sample);
         end
         OP_READ: begin
            if (int'(w.column) < pw && int'(w.row) < ph)
               r.read_data = mem_get(w.plane, int'(w.row) * pw + int'(w.column));
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type make_word(input op_type op, input logic [1:0] p,
                                         input logic [7:0] col, input logic [7:0] row,
                                         input logic [7:0] smp);
      req_type w;
      w.operation = op;
      w.plane     = p;
      w.column    = col;
      w.row       = row;
      w.sample    = smp;
      return w;
   endfunction

   // A read of a never-written in-frame entry is not allowed; callers redirect it to the spare plane.
   function automatic bit read_allowed(input req_type w);
      int pw, ph;
      pw = plane_w(w.plane);
      ph = plane_h(w.plane);
      if (int'(w.column) < pw && int'(w.row) < ph)
         return mem_known(w.plane, int'(w.row) * pw + int'(w.column));
      return 1'b1;
   endfunction

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owed_rsp.push_back(run_frame_op(w));
      words_sent++;
   endtask

   task automatic send_noise();
      req_type w;
      w = req_type'(REQ_BITS'($urandom));
      case ($urandom_range(3))
         0:       w.operation = OP_NONE;
         1:       w.plane = PLANE_SPARE;
         default: ;
      endcase
      // apply needs filled scan rows, so keep it out of the noise
      if (w.operation == OP_APPLY)
         w.operation = OP_NONE;
      if (w.operation == OP_READ && !read_allowed(w))
         w.plane = PLANE_SPARE;
      send_word(w);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (owed_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width   = value;
         CSR_FRAME_HEIGHT:   cfg_height  = value;
         CSR_LINE_SPACING:   cfg_spacing = value;
         CSR_VERTICAL_SCALE: cfg_scale   = value;
         CSR_LUMA_COLOR:     cfg_luma    = value[7:0];
         CSR_CR_COLOR:       cfg_cr      = value[7:0];
         CSR_CB_COLOR:       cfg_cb      = value[7:0];
         CSR_CHROMA_RANGE:   cfg_chroma  = value[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_frame(input int wv, input int hv, input int sp, input int sc,
                            input int luma, input int cr, input int cb, input int chroma);
      wait_for_replies();
      write_reg(CSR_FRAME_WIDTH, 9'(wv));
      write_reg(CSR_FRAME_HEIGHT, 9'(hv));
      write_reg(CSR_LINE_SPACING, 9'(sp));
      write_reg(CSR_VERTICAL_SCALE, 9'(sc));
      write_reg(CSR_LUMA_COLOR, 9'(luma));
      write_reg(CSR_CR_COLOR, 9'(cr));
      write_reg(CSR_CB_COLOR, 9'(cb));
      write_reg(CSR_CHROMA_RANGE, 9'(chroma));
   endtask

   // Load every scan row afresh; on small planes also any entry not yet written.
   task automatic fill_frame();
      int         pw, ph, step, a;
      logic [1:0] p;
      logic [7:0] smp;
      step = (cfg_spacing == 0) ? 1 : int'(cfg_spacing);
      for (int k = 0; k < 3; k++) begin
         p = k[1:0];
         if (p != PLANE_LUMA && cfg_chroma == 0)
            continue;
         pw = plane_w(p);
         ph = plane_h(p);
         for (int y = 0; y < ph; y++) begin
            for (int x = 0; x < pw; x++) begin
               a = y * pw + x;
               if (y % step == 0 || (!mem_known(p, a) && pw * ph <= 100)) begin
                  if ($urandom_range(99) < 8)
                     send_noise();
                  // small samples give short displacements that land in the frame
                  smp = 8'($urandom_range(1) ? $urandom_range(255) : $urandom_range(15));
                  send_word(make_word(OP_LOAD, p, 8'(x), 8'(y), smp));
               end
            end
         end
      end
   endtask

   task automatic apply_effect();
      send_word(make_word(OP_APPLY, 2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          8'($urandom)));
   endtask

   task automatic read_back(input int count);
      int         pw, ph, step, x, y;
      logic [1:0] p;
      req_type    w;
      step = (cfg_spacing == 0) ? 1 : int'(cfg_spacing);
      repeat (count) begin
         p  = $urandom_range(1) ? PLANE_LUMA : 2'($urandom_range(2));
         pw = plane_w(p);
         ph = plane_h(p);
         x  = $urandom_range(pw - 1);
         if ($urandom_range(1))
            y = step * $urandom_range((ph - 1) / step);
         else
            y = $urandom_range(ph - 1);
         w = make_word(OP_READ, p, 8'(x), 8'(y), 8'($urandom));
         if (!read_allowed(w))
            w.plane = PLANE_SPARE;
         if ($urandom_range(99) < 8)
            send_noise();
         send_word(w);
      end
   endtask

   task automatic test_reset_values();
      send_word(make_word(OP_LOAD, PLANE_LUMA, 8'd0, 8'd0, 8'h00));
      send_word(make_word(OP_LOAD, PLANE_LUMA, 8'd255, 8'd255, 8'hff));
      send_word(make_word(OP_LOAD, PLANE_CR, 8'd127, 8'd127, 8'h5a));
      send_word(make_word(OP_LOAD, PLANE_CB, 8'd0, 8'd127, 8'ha5));
      // outside the chroma plane and on the spare plane: both dropped
      send_word(make_word(OP_LOAD, PLANE_CR, 8'd128, 8'd0, 8'h3c));
      send_word(make_word(OP_LOAD, PLANE_SPARE, 8'd1, 8'd1, 8'hc3));
      send_word(make_word(OP_NONE, PLANE_SPARE, 8'd255, 8'd255, 8'hff));
      send_word(make_word(OP_READ, PLANE_LUMA, 8'd255, 8'd255, 8'h00));
      send_word(make_word(OP_READ, PLANE_LUMA, 8'd0, 8'd0, 8'hff));
      send_word(make_word(OP_READ, PLANE_CR, 8'd127, 8'd127, 8'h00));
      send_word(make_word(OP_READ, PLANE_CB, 8'd0, 8'd127, 8'h00));
      send_word(make_word(OP_READ, PLANE_CR, 8'd128, 8'd0, 8'h00));
      send_word(make_word(OP_READ, PLANE_CB, 8'd5, 8'd200, 8'h00));
      send_word(make_word(OP_READ, PLANE_SPARE, 8'd0, 8'd0, 8'h00));
   endtask

   task automatic test_backpressure();
      holdoff_requests++;
      for (int c = 0; c < 6; c++)
         send_word(make_word(OP_LOAD, PLANE_LUMA, 8'(c), 8'd1, 8'($urandom)));
      for (int c = 0; c < 6; c++)
         send_word(make_word(OP_READ, PLANE_LUMA, 8'(c), 8'd1, 8'h00));
   endtask

   task automatic test_wide_frame();
      // width clamps to the maximum, height and spacing up from their floors
      steady = 1'b1;
      set_frame(511, 1, 0, 128, 255, 0, 255, 0);
      fill_frame();
      apply_effect();
      read_back(24);
      steady = 1'b0;
   endtask

   task automatic test_tall_frame();
      set_frame(0, 300, 17, 0, 0, 255, 0, 7);
      fill_frame();
      apply_effect();
      read_back(24);
   endtask

   task automatic random_phase();
      int r, wv, hv, sp, sc;
      r = $urandom_range(99);
      if (r < 6) begin
         wv = $urandom_range(1);
         hv = $urandom_range(2, 12);
      end else if (r < 12) begin
         wv = $urandom_range(2, 12);
         hv = $urandom_range(1);
      end else if (r < 82) begin
         wv = $urandom_range(2, 12);
         hv = $urandom_range(2, 12);
      end else if (r < 91) begin
         wv = $urandom_range(13, 40);
         hv = $urandom_range(2, 4);
      end else begin
         wv = $urandom_range(2, 4);
         hv = $urandom_range(13, 40);
      end
      r = $urandom_range(99);
      sp = (r < 8) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 511);
      r = $urandom_range(99);
      if (r < 10)
         sc = 0;
      else if (r < 30)
         sc = $urandom_range(1, 4);
      else if (r < 80)
         sc = $urandom_range(5, 64);
      else
         sc = $urandom_range(65, 511);
      set_frame(wv, hv, sp, sc, $urandom_range(255), $urandom_range(255),
                $urandom_range(255), ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7));
      fill_frame();
      apply_effect();
      read_back($urandom_range(8, 24));
      if ($urandom_range(3) == 0) begin
         apply_effect();
         read_back(8);
      end
   endtask

   task automatic test_random_frames();
      while (words_sent < ITEM_TARGET)
         random_phase();
   endtask

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests != holds_seen) begin
            holds_seen = holdoff_requests;
            hold_left  = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_rsp.size() == 0) begin
            $display("%0t: response word with nothing pending: read_data %0d op %0d",
                     $time, rsp_data.read_data, rsp_data.finished_operation);
            error_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $display("%0t: read_data expected %0d got %0d",
                        $time, want.read_data, rsp_data.read_data);
               error_count++;
            end
            if (rsp_data.finished_operation !== want.finished_operation) begin
               $display("%0t: finished_operation expected %0d got %0d",
                        $time, want.finished_operation, rsp_data.finished_operation);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(15_000_000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= '0;
      cfg_width   = 9'd256;
      cfg_height  = 9'd256;
      cfg_spacing = 9'd2;
      cfg_scale   = 9'd42;
      cfg_luma    = 8'd201;
      cfg_cr      = 8'd128;
      cfg_cb      = 8'd128;
      cfg_chroma  = 3'd6;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_backpressure();
      test_wide_frame();
      test_tall_frame();
      test_random_frames();

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sde_pkg.sv
hw/rtl/scanline_displacement_effect.sv
tb/tb.sv
